/* design/ptame_pkg.sv */
`timescale 1ns / 1ps

package ptame_pkg;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } ptame_op_t;

  localparam logic [7:0] CFG_TIMEOUT  = 8'd0;
  localparam logic [7:0] CFG_OWN_ADDR = 8'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] peer_address;
    logic [15:0] light_level;
  } ptame_in_t;

  typedef struct packed {
    logic       is_master;
    logic [4:0] peer_count;
    logic       report_dropped;
  } ptame_out_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] level;
    logic [31:0] stamp;
  } ptame_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } ptame_state_t;

  typedef struct packed {
    logic start;
    logic read;
    logic commit;
  } ptame_cmd_t;

  typedef struct packed {
    logic last_idx;
    logic out_free;
  } ptame_sts_t;

endpackage

/* design/ptame_ctrl.sv */
`timescale 1ns / 1ps

module ptame_ctrl import ptame_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ptame_sts_t sts,
  output ptame_cmd_t cmd
);

  ptame_state_t state_r;
  ptame_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.read   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SWEEP: begin
        cmd.read = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/ptame_dp.sv */
`timescale 1ns / 1ps

module ptame_dp import ptame_pkg::*; #(
  parameter int MAX_PEERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ptame_cmd_t  cmd,
  output ptame_sts_t  sts,
  input  ptame_in_t   in_data,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ptame_out_t  out_data
);

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);

  ptame_entry_t mem [MAX_PEERS];

  logic [15:0]          timeout_r;
  logic [31:0]          own_addr_r;
  logic [31:0]          time_now_r;
  logic [15:0]          own_level_r;
  logic [1:0]           op_r;
  logic [31:0]          addr_r;
  logic [15:0]          level_r;
  logic                 match_en_r;
  logic [MAX_PEERS-1:0] valid_r;
  logic [IW-1:0]        idx_r;
  logic                 rd_vld_r;
  logic [IW-1:0]        rd_idx_r;
  ptame_entry_t         rd_data_r;
  logic [CW-1:0]        cnt_r;
  logic                 master_r;
  logic                 hit_r;
  logic [IW-1:0]        hit_idx_r;
  logic                 free_r;
  logic [IW-1:0]        free_idx_r;
  logic                 out_valid_r;
  ptame_out_t           out_data_r;

  logic          entry_v;
  logic [31:0]   age;
  logic          expired;
  logic          is_hit;
  logic          is_free;
  logic          live;
  logic          found;
  logic          insert;
  logic [IW-1:0] wr_idx;
  ptame_out_t    result;

  always_comb begin
    entry_v = valid_r[rd_idx_r];
    age     = time_now_r - rd_data_r.stamp;
    expired = (op_r == OP_TICK) && entry_v && (age > {16'b0, timeout_r});
    is_hit  = match_en_r && entry_v && (rd_data_r.address == addr_r);
    is_free = match_en_r && !entry_v && !free_r;
    live    = entry_v && !expired && !is_hit;
    found   = hit_r || free_r;
    insert  = match_en_r && !hit_r && free_r;
    wr_idx  = hit_r ? hit_idx_r : free_idx_r;
    result.is_master      = master_r && !(found && (own_level_r < level_r));
    result.peer_count     = 5'(cnt_r + CW'(found));
    result.report_dropped = match_en_r && !found;
  end

  assign sts.last_idx = (idx_r == IW'(MAX_PEERS - 1));
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.commit && match_en_r && found) begin
      mem[wr_idx] <= '{address: addr_r, level: level_r, stamp: time_now_r};
    end
    if (cmd.read) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= in_data.opcode;
      addr_r   <= in_data.peer_address;
      level_r  <= in_data.light_level;
      cnt_r    <= '0;
      master_r <= 1'b1;
    end else if (rd_vld_r) begin
      if (is_hit) begin
        hit_idx_r <= rd_idx_r;
      end
      if (is_free) begin
        free_idx_r <= rd_idx_r;
      end
      if (live) begin
        cnt_r <= cnt_r + CW'(1);
        if (own_level_r < rd_data_r.level) begin
          master_r <= 1'b0;
        end
      end
    end
    if (cmd.commit) begin
      out_data_r <= result;
    end
    rd_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      own_addr_r  <= '0;
      time_now_r  <= '0;
      own_level_r <= '0;
      match_en_r  <= 1'b0;
      valid_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TIMEOUT: begin
            timeout_r <= cfg_data[15:0];
          end
          CFG_OWN_ADDR: begin
            own_addr_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      rd_vld_r <= cmd.read;
      if (cmd.start) begin
        match_en_r <= (in_data.opcode == OP_REPORT) && (in_data.peer_address != own_addr_r);
        idx_r      <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
        if (in_data.opcode == OP_TICK) begin
          time_now_r <= time_now_r + 32'd1;
        end
        if (in_data.opcode == OP_SAMPLE) begin
          own_level_r <= in_data.light_level;
        end
      end else if (cmd.read) begin
        idx_r <= idx_r + IW'(1);
      end
      if (rd_vld_r) begin
        if (is_hit) begin
          hit_r <= 1'b1;
        end
        if (is_free) begin
          free_r <= 1'b1;
        end
        if (expired) begin
          valid_r[rd_idx_r] <= 1'b0;
        end
      end
      if (cmd.commit && insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_drop_only_report: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (!out_data_r.report_dropped || $past(op_r) == OP_REPORT))
    else $error("drop flagged on an item that is not a peer report");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && in_data.opcode == OP_TICK) |=> time_now_r == $past(time_now_r) + 32'd1)
    else $error("tick did not advance the millisecond counter by one");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && insert) |-> !valid_r[free_idx_r])
    else $error("new peer written over a valid entry");

  a_no_read_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!cmd.read && !rd_vld_r))
    else $error("result committed while a table read is in flight");

endmodule

/* design/peer_table_aging_max_election.sv */
`timescale 1ns / 1ps

// Peer table with timeout aging and master election.
// The input channel (in_valid, in_ready, in_data) takes one word per item:
// a peer report, a one millisecond tick or a local light sample. Every item
// gives exactly one word on the result channel (out_valid, out_ready,
// out_data) with the master flag, the peer count and the drop flag.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the timeout and the own address; it is always ready. The user
// must use it only while no item is in progress; the block does not check.
// Each item sweeps the whole table through its single read port, one entry
// per cycle; a new word is taken only once the previous item has passed the
// sweep, drain and done states and its result has been committed.
// A finished result sits in an output register, and the next input word is
// accepted while it waits; the sweep of that word stalls at its end until
// the receiver takes the older result.
// Reset empties the table, clears time and own level, restores the timeout
// to 5000 ms and the own address to zero. Table contents need no clearing.

module peer_table_aging_max_election import ptame_pkg::*; #(
  parameter int MAX_PEERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ptame_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ptame_out_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ptame_cmd_t cmd;
  ptame_sts_t sts;

  assign cfg_ready = 1'b1;

  ptame_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptame_dp #(
    .MAX_PEERS (MAX_PEERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_peer_table_aging_max_election.sv */
`timescale 1ns / 1ps

module tb_peer_table_aging_max_election;
  import ptame_pkg::*;

  localparam int PEERS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 20;
  localparam int PHASE_ITEMS = 250;

  class peer_election_scoreboard;
    bit          slot_valid [PEERS];
    logic [31:0] slot_addr  [PEERS];
    logic [15:0] slot_level [PEERS];
    logic [31:0] slot_stamp [PEERS];
    logic [31:0] clock_ms;
    logic [15:0] own_lux;
    logic [15:0] age_limit;
    logic [31:0] self_addr;
    ptame_out_t  expected_words [$];
    int          errors;
    int          items;
    int          drops;
    int          removals;
    int          master_words;

    function new();
      for (int i = 0; i < PEERS; i++) slot_valid[i] = 1'b0;
      clock_ms  = '0;
      own_lux   = '0;
      age_limit = TIMEOUT_RESET;
      self_addr = '0;
      errors = 0;
      items = 0;
      drops = 0;
      removals = 0;
      master_words = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] value);
      if (idx == CFG_TIMEOUT) age_limit = value[15:0];
      else if (idx == CFG_OWN_ADDR) self_addr = value;
    endfunction

    function void note_word(ptame_in_t w);
      int         hit;
      int         free_slot;
      int         cnt;
      logic [31:0] age;
      ptame_out_t e;
      e = '0;
      e.is_master = 1'b1;
      hit = -1;
      free_slot = -1;
      cnt = 0;
      items++;
      case (w.opcode)
        OP_REPORT: begin
          if (w.peer_address != self_addr) begin
            for (int i = 0; i < PEERS; i++) begin
              if (slot_valid[i] && slot_addr[i] == w.peer_address && hit < 0) hit = i;
              if (!slot_valid[i] && free_slot < 0) free_slot = i;
            end
            if (hit >= 0) begin
              slot_level[hit] = w.light_level;
              slot_stamp[hit] = clock_ms;
            end else if (free_slot >= 0) begin
              slot_valid[free_slot] = 1'b1;
              slot_addr[free_slot]  = w.peer_address;
              slot_level[free_slot] = w.light_level;
              slot_stamp[free_slot] = clock_ms;
            end else begin
              e.report_dropped = 1'b1;
              drops++;
            end
          end
        end
        OP_TICK: begin
          clock_ms = clock_ms + 32'd1;
          for (int i = 0; i < PEERS; i++) begin
            age = clock_ms - slot_stamp[i];
            if (slot_valid[i] && age > {16'd0, age_limit}) begin
              slot_valid[i] = 1'b0;
              removals++;
            end
          end
        end
        OP_SAMPLE: own_lux = w.light_level;
        default: ;
      endcase
      for (int i = 0; i < PEERS; i++) begin
        if (slot_valid[i]) begin
          cnt++;
          if (own_lux < slot_level[i]) e.is_master = 1'b0;
        end
      end
      e.peer_count = cnt[4:0];
      if (e.is_master) master_words++;
      expected_words.push_back(e);
    endfunction

    function void check_word(ptame_out_t got);
      ptame_out_t e;
      if (expected_words.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got.is_master !== e.is_master) begin
        $error("is_master: expected %0d, got %0d", e.is_master, got.is_master);
        errors++;
      end
      if (got.peer_count !== e.peer_count) begin
        $error("peer_count: expected %0d, got %0d", e.peer_count, got.peer_count);
        errors++;
      end
      if (got.report_dropped !== e.report_dropped) begin
        $error("report_dropped: expected %0d, got %0d", e.report_dropped,
               got.report_dropped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ptame_in_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ptame_out_t  out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  peer_election_scoreboard sb = new();
  logic [31:0] addr_pool [POOL_SIZE];
  logic [31:0] cur_own = '0;
  int          sent = 0;
  int          settings = 0;

  peer_table_aging_max_election #(.MAX_PEERS(PEERS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_word(out_data);
      if (in_valid && in_ready) sb.note_word(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // The result side holds off twice for a long stretch so that the block
  // fills up and stops taking input words.
  initial begin : result_sink
    int taken;
    int gap;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) gap = 400;
      else if ((taken / 80) % 4 == 2) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  function automatic ptame_in_t make_word(ptame_op_t op, logic [31:0] a, logic [15:0] l);
    ptame_in_t w;
    w.opcode = op;
    w.peer_address = a;
    w.light_level = l;
    return w;
  endfunction

  task automatic send_word(ptame_in_t w);
    int gap;
    gap = ((sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PEERS + 4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] timeout, logic [31:0] own);
    drain();
    write_reg(CFG_TIMEOUT, {16'd0, timeout});
    write_reg(CFG_OWN_ADDR, own);
    cur_own = own;
    settings++;
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    int          r;
    int          s;
    logic [31:0] a;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        s = $urandom_range(0, 19);
        if (s < 17) a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (s == 17) a = cur_own;
        else a = $urandom;
        send_word(make_word(OP_REPORT, a, pick_level()));
      end else if (r < 80) begin
        send_word(make_word(OP_TICK, $urandom, 16'($urandom)));
      end else if (r < 95) begin
        send_word(make_word(OP_SAMPLE, $urandom, pick_level()));
      end else begin
        send_word(make_word(OP_NONE, $urandom, 16'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(OP_SAMPLE, 32'h0, 16'h0000));
    send_word(make_word(OP_REPORT, 32'h0, 16'hFFFF));
    send_word(make_word(OP_REPORT, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(OP_REPORT, 32'h1, 16'h0000));
    send_word(make_word(OP_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(OP_REPORT, 32'hFFFF_FFFF, 16'h0000));
    send_word(make_word(OP_NONE, 32'hAAAA_AAAA, 16'h5555));
    send_word(make_word(OP_TICK, 32'h5555_5555, 16'hAAAA));
    for (int i = 0; i < PEERS - 2; i++)
      send_word(make_word(OP_REPORT, 32'h100 + i, 16'(i * 4000)));
    send_word(make_word(OP_REPORT, 32'h1234_5678, 16'h7FFF));
    send_word(make_word(OP_SAMPLE, 32'h0, 16'h8000));

    apply_setting(16'd0, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);
    apply_setting(16'd1, $urandom);
    random_phase(PHASE_ITEMS);
    apply_setting(16'hFFFF, 32'h0);
    random_phase(PHASE_ITEMS);
    apply_setting(16'd3, $urandom);
    random_phase(PHASE_ITEMS);
    apply_setting(16'($urandom_range(2, 40)), $urandom);
    random_phase(PHASE_ITEMS);
    apply_setting(16'($urandom), $urandom);
    random_phase(PHASE_ITEMS);

    drain();
    if (sb.pending() != 0) begin
      $error("%0d expected result words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d input words under %0d register settings after reset.",
             sb.items, settings);
    $display("Full-table drops: %0d, aged-out peers: %0d, master results: %0d.",
             sb.drops, sb.removals, sb.master_words);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
